@@ hdl/spvd_pkg.sv @@
// Package for the stream peak and valley detector.
// Holds the field widths, the transaction payload types and the slope codes.
// No dependencies.
package spvd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int INDEX_BITS  = 16;

  typedef enum logic [1:0] {
    SLOPE_NONE = 2'b00,
    SLOPE_UP   = 2'b01,
    SLOPE_DOWN = 2'b10
  } slope_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;
  } item_t;

  typedef struct packed {
    logic        [INDEX_BITS-1:0]  peak_index;
    logic signed [SAMPLE_BITS-1:0] peak_value;
    logic        [INDEX_BITS-1:0]  spread;
    logic                          is_minimum;
  } peak_t;

  typedef struct packed {
    logic  hit;
    peak_t peak;
  } detect_t;

endpackage

@@ hdl/stream_peak_valley_detector.sv @@
// The block takes one signed sample per transaction and reports local maxima and
// minima, including flat runs, as result transactions. It accepts one sample in
// every cycle while the output is not stalled; a sample passes through an input
// register, and its result through a result register. While a result waits on a stalled output,
// one more sample is taken into the input register before the input stalls too.
// Depends on spvd_pkg and spvd_detect.
module stream_peak_valley_detector (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  spvd_pkg::item_t item,
  output logic            peak_valid,
  input  logic            peak_ready,
  output spvd_pkg::peak_t peak
);

  logic              held_valid;
  spvd_pkg::item_t   held_item;
  logic              advance;
  logic              step;
  spvd_pkg::detect_t detect;

  assign advance    = !peak_valid || peak_ready;
  assign item_ready = !held_valid || advance;
  assign step       = held_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held_item <= item;
    end
  end

  spvd_detect u_detect (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (held_item),
    .detect (detect)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_valid <= 1'b0;
    end else if (advance) begin
      peak_valid <= step && detect.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && detect.hit) begin
      peak <= detect.peak;
    end
  end

endmodule

@@ hdl/spvd_detect.sv @@
// Detection state and slope logic of the stream peak and valley detector.
// Processes one sample per step and reports at most one extremum for it.
// Depends on spvd_pkg.
module spvd_detect (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  spvd_pkg::item_t        item,
  output spvd_pkg::detect_t      detect
);

  localparam int IB = spvd_pkg::INDEX_BITS;
  localparam int SB = spvd_pkg::SAMPLE_BITS;
  localparam logic [IB-1:0] COUNT_MAX = {IB{1'b1}};
  localparam logic [IB-1:0] ONE = {{(IB-1){1'b0}}, 1'b1};

  logic signed [SB-1:0] previous_sample, previous_sample_next;
  spvd_pkg::slope_t     previous_slope, previous_slope_next;
  logic [IB-1:0]        sample_counter, sample_counter_next;
  logic                 in_plateau, in_plateau_next;
  logic [IB-1:0]        plateau_start, plateau_start_next;
  spvd_pkg::slope_t     slope_before, slope_before_next;

  spvd_pkg::slope_t     cur;
  logic                 seen_one;
  logic                 seen_two;
  logic [IB:0]          index_sum;
  logic [IB-1:0]        last_index;

  always_comb begin
    seen_one   = (sample_counter != '0);
    seen_two   = (sample_counter > ONE);
    last_index = sample_counter - ONE;
    index_sum  = {1'b0, last_index} + {1'b0, plateau_start};

    if (!seen_one) begin
      cur = spvd_pkg::SLOPE_NONE;
    end else if ($signed(item.sample) > previous_sample) begin
      cur = spvd_pkg::SLOPE_UP;
    end else if ($signed(item.sample) < previous_sample) begin
      cur = spvd_pkg::SLOPE_DOWN;
    end else begin
      cur = spvd_pkg::SLOPE_NONE;
    end

    previous_sample_next = item.sample;
    previous_slope_next  = seen_one ? cur : previous_slope;
    sample_counter_next  = (sample_counter == COUNT_MAX) ? sample_counter
                                                         : sample_counter + ONE;
    in_plateau_next      = in_plateau;
    plateau_start_next   = plateau_start;
    slope_before_next    = slope_before;

    detect.hit             = 1'b0;
    detect.peak.peak_index = last_index;
    detect.peak.peak_value = previous_sample;
    detect.peak.spread     = ONE;
    detect.peak.is_minimum = (previous_slope == spvd_pkg::SLOPE_DOWN);

    if (seen_two) begin
      if (!in_plateau) begin
        if ((previous_slope == spvd_pkg::SLOPE_UP && cur == spvd_pkg::SLOPE_DOWN) ||
            (previous_slope == spvd_pkg::SLOPE_DOWN && cur == spvd_pkg::SLOPE_UP)) begin
          detect.hit = 1'b1;
        end
        if (cur == spvd_pkg::SLOPE_NONE) begin
          in_plateau_next    = 1'b1;
          plateau_start_next = sample_counter;
          slope_before_next  = previous_slope;
        end
      end else if (cur != spvd_pkg::SLOPE_NONE) begin
        detect.peak.peak_index = index_sum[IB:1];
        detect.peak.spread     = sample_counter - plateau_start + ONE;
        if (slope_before == spvd_pkg::SLOPE_UP && cur == spvd_pkg::SLOPE_DOWN) begin
          detect.hit             = 1'b1;
          detect.peak.is_minimum = 1'b0;
        end else if (slope_before == spvd_pkg::SLOPE_DOWN &&
                     cur == spvd_pkg::SLOPE_UP) begin
          detect.hit             = 1'b1;
          detect.peak.is_minimum = 1'b1;
        end
        in_plateau_next = 1'b0;
      end
    end

    if (item.last_sample) begin
      previous_sample_next = '0;
      previous_slope_next  = spvd_pkg::SLOPE_NONE;
      sample_counter_next  = '0;
      in_plateau_next      = 1'b0;
      plateau_start_next   = '0;
      slope_before_next    = spvd_pkg::SLOPE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
      previous_slope  <= spvd_pkg::SLOPE_NONE;
      sample_counter  <= '0;
      in_plateau      <= 1'b0;
      plateau_start   <= '0;
      slope_before    <= spvd_pkg::SLOPE_NONE;
    end else if (step) begin
      previous_sample <= previous_sample_next;
      previous_slope  <= previous_slope_next;
      sample_counter  <= sample_counter_next;
      in_plateau      <= in_plateau_next;
      plateau_start   <= plateau_start_next;
      slope_before    <= slope_before_next;
    end
  end

endmodule

@@ hdl/spvd_checker.sv @@
// Port-level checks for the stream peak and valley detector.
// Bound to stream_peak_valley_detector; depends on spvd_pkg.
module spvd_checker (
  input logic            clk,
  input logic            rst,
  input logic            item_ready,
  input logic            peak_valid,
  input logic            peak_ready,
  input spvd_pkg::peak_t peak
);

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    peak_valid && !peak_ready |=> peak_valid && $stable(peak))
    else $error("Stalled result transaction changed.");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !peak_valid)
    else $error("Result valid after reset.");

  a_spread_nonzero: assert property (@(posedge clk) disable iff (rst)
    peak_valid |-> peak.spread != '0)
    else $error("Result with zero spread.");

  a_index_nonzero: assert property (@(posedge clk) disable iff (rst)
    peak_valid |-> peak.peak_index != '0)
    else $error("Extremum reported at the first sample.");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> peak_valid && !peak_ready)
    else $error("Input stalled without a stalled result.");

endmodule

bind stream_peak_valley_detector spvd_checker u_spvd_checker (
  .clk        (clk),
  .rst        (rst),
  .item_ready (item_ready),
  .peak_valid (peak_valid),
  .peak_ready (peak_ready),
  .peak       (peak)
);

@@ dv/testbench.sv @@
// Testbench for the stream peak and valley detector, checked against its own
// model of extremum detection with flat runs and index saturation.
// Depends on spvd_pkg and the stream_peak_valley_detector RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int SB       = spvd_pkg::SAMPLE_BITS;
  localparam int IB       = spvd_pkg::INDEX_BITS;
  localparam int HOLD_LEN = 400;

  typedef enum int {
    SHAPE_WALK,
    SHAPE_FLATS,
    SHAPE_RAIL,
    SHAPE_WIDE
  } shape_t;

  class peak_scoreboard;
    spvd_pkg::peak_t         expected_peaks[$];
    logic signed [SB-1:0]    last_value;
    spvd_pkg::slope_t        last_slope;
    logic [IB-1:0]           next_index;
    bit                      flat_open;
    logic [IB-1:0]           flat_start;
    spvd_pkg::slope_t        slope_into_flat;
    int unsigned samples_seen, signals_ended, peaks_checked, mismatches;
    int unsigned maxima, minima, flat_peaks;

    function new();
      clear_signal();
    endfunction

    function void clear_signal();
      last_value      = '0;
      last_slope      = spvd_pkg::SLOPE_NONE;
      next_index      = '0;
      flat_open       = 1'b0;
      flat_start      = '0;
      slope_into_flat = spvd_pkg::SLOPE_NONE;
    endfunction

    function void note_sample(spvd_pkg::item_t it);
      spvd_pkg::slope_t now_slope;
      spvd_pkg::peak_t  p;
      bit               hit;
      int unsigned      run_end;
      now_slope = spvd_pkg::SLOPE_NONE;
      p = '0;
      hit = 1'b0;
      samples_seen++;
      if (next_index != 0) begin
        if ($signed(it.sample) > last_value) begin
          now_slope = spvd_pkg::SLOPE_UP;
        end else if ($signed(it.sample) < last_value) begin
          now_slope = spvd_pkg::SLOPE_DOWN;
        end
      end
      if (next_index >= 2) begin
        p.peak_value = last_value;
        if (!flat_open) begin
          if ((last_slope == spvd_pkg::SLOPE_UP && now_slope == spvd_pkg::SLOPE_DOWN) ||
              (last_slope == spvd_pkg::SLOPE_DOWN && now_slope == spvd_pkg::SLOPE_UP)) begin
            hit = 1'b1;
            p.peak_index = next_index - 1'b1;
            p.spread = IB'(1);
            p.is_minimum = (last_slope == spvd_pkg::SLOPE_DOWN);
          end
          if (now_slope == spvd_pkg::SLOPE_NONE) begin
            flat_open = 1'b1;
            flat_start = next_index;
            slope_into_flat = last_slope;
          end
        end else if (now_slope != spvd_pkg::SLOPE_NONE) begin
          run_end = next_index - 1;
          p.peak_index = IB'((run_end + flat_start) / 2);
          p.spread = next_index - flat_start + 1'b1;
          if (slope_into_flat == spvd_pkg::SLOPE_UP && now_slope == spvd_pkg::SLOPE_DOWN) begin
            hit = 1'b1;
            p.is_minimum = 1'b0;
          end else if (slope_into_flat == spvd_pkg::SLOPE_DOWN &&
                       now_slope == spvd_pkg::SLOPE_UP) begin
            hit = 1'b1;
            p.is_minimum = 1'b1;
          end
          if (hit) flat_peaks++;
          flat_open = 1'b0;
        end
      end
      if (next_index != 0) last_slope = now_slope;
      last_value = it.sample;
      if (next_index != '1) next_index++;
      if (it.last_sample) begin
        signals_ended++;
        clear_signal();
      end
      if (hit) begin
        if (p.is_minimum) minima++;
        else maxima++;
        expected_peaks.push_back(p);
      end
    endfunction

    function void check_peak(spvd_pkg::peak_t got);
      spvd_pkg::peak_t want;
      peaks_checked++;
      if (expected_peaks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result at %0t: idx=%0d val=%0d spread=%0d min=%0b",
                   $realtime, got.peak_index, got.peak_value, got.spread, got.is_minimum);
        return;
      end
      want = expected_peaks.pop_front();
      if (got.peak_index !== want.peak_index || got.peak_value !== want.peak_value ||
          got.spread !== want.spread || got.is_minimum !== want.is_minimum) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"Mismatch at %0t: expected idx=%0d val=%0d spread=%0d min=%0b,",
                    " got idx=%0d val=%0d spread=%0d min=%0b"}, $realtime,
                   want.peak_index, want.peak_value, want.spread, want.is_minimum,
                   got.peak_index, got.peak_value, got.spread, got.is_minimum);
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst;
  logic            item_valid;
  logic            item_ready;
  spvd_pkg::item_t item;
  logic            peak_valid;
  logic            peak_ready;
  spvd_pkg::peak_t peak;

  peak_scoreboard board;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  logic           hold_start;
  int unsigned    hold_cycles;
  bit             hold_done;

  stream_peak_valley_detector i_dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .peak_valid (peak_valid),
    .peak_ready (peak_ready),
    .peak       (peak)
  );

  always #5 clk = ~clk;

  function automatic logic signed [SB-1:0] pick_sample(
      shape_t shape, logic signed [SB-1:0] prev);
    case (shape)
      SHAPE_WALK: return SB'(prev + $urandom_range(4) - 2);
      SHAPE_FLATS: begin
        if ($urandom_range(9) < 6) return prev;
        return SB'(prev + $urandom_range(64) - 32);
      end
      SHAPE_RAIL: begin
        case ($urandom_range(4))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh8001;
          3: return 16'sh7FFE;
          default: return '0;
        endcase
      end
      default: return SB'($urandom);
    endcase
  endfunction

  task automatic send_sample(logic signed [SB-1:0] value, bit last);
    spvd_pkg::item_t it;
    it.sample = value;
    it.last_sample = last;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    board.note_sample(it);
  endtask

  task automatic send_random_signals(int unsigned budget);
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    shape_t      shape;
    logic signed [SB-1:0] value;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(99);
      if (r < 5) len = 1;
      else if (r < 85) len = $urandom_range(40, 2);
      else len = $urandom_range(200, 41);
      r = $urandom_range(99);
      if (r < 40) shape = SHAPE_WALK;
      else if (r < 70) shape = SHAPE_FLATS;
      else if (r < 80) shape = SHAPE_RAIL;
      else shape = SHAPE_WIDE;
      value = SB'($urandom);
      for (int i = 0; i < len; i++) begin
        value = pick_sample(shape, value);
        send_sample(value, i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    peak_ready <= 1'b0;
    hold_cycles = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && peak_valid && peak_ready) board.check_peak(peak);
      if (hold_start && !hold_done) begin
        peak_ready <= 1'b0;
        hold_cycles++;
        if (hold_cycles == HOLD_LEN) hold_done = 1'b1;
      end else begin
        peak_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Timeout waiting for the detector");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned failures;
    board = new();
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    hold_start <= 1'b0;
    send_idle_pct = 38;
    recv_idle_pct <= 81;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // A flat start that is never reported, a sharp valley, an open flat run at the end.
    send_sample(5, 0);
    send_sample(5, 0);
    send_sample(3, 0);
    send_sample(7, 0);
    send_sample(7, 1);
    // Full-scale swings.
    send_sample(-32768, 0);
    send_sample(32767, 0);
    send_sample(-32768, 0);
    send_sample(32767, 1);
    // A flat maximum.
    send_sample(0, 0);
    send_sample(1, 0);
    send_sample(4, 0);
    send_sample(4, 0);
    send_sample(4, 0);
    send_sample(2, 1);
    // A flat minimum, a flat step with the same slope on both sides, a sharp peak.
    send_sample(10, 0);
    send_sample(-5, 0);
    send_sample(-5, 0);
    send_sample(-5, 0);
    send_sample(-5, 0);
    send_sample(8, 0);
    send_sample(8, 0);
    send_sample(20, 0);
    send_sample(0, 1);
    // A signal of one sample.
    send_sample(32767, 1);

    send_random_signals(500);

    send_idle_pct = 81;
    recv_idle_pct <= 38;
    send_random_signals(500);

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_start <= 1'b1;
    send_random_signals(500);
    item_valid <= 1'b0;

    while (board.expected_peaks.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    failures = board.mismatches + board.expected_peaks.size();
    $display("Sent %0d samples in %0d signals of walking, flat, full-scale and wide shapes.",
             board.samples_seen, board.signals_ended);
    $display("Checked %0d results: %0d maxima, %0d minima, %0d of them from flat runs.",
             board.peaks_checked, board.maxima, board.minima, board.flat_peaks);
    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d failures", failures);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
